FILE: src/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared codes, field widths and the command type of the timer queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  // field widths fixed by the channel format
  localparam int IN_TIME_W  = 48;
  localparam int OUT_TIME_W = 48;
  localparam int HDL_W      = 32;
  localparam int IV_W       = 32;
  localparam int CNT_W      = 6;
  localparam int MAX_TIME_W = 64;

  // operations
  localparam logic [1:0] OP_SCHED   = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_PROCESS = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_SCHED   = 3'd0;
  localparam logic [2:0] KIND_CANCEL  = 3'd1;
  localparam logic [2:0] KIND_FIRED   = 3'd2;
  localparam logic [2:0] KIND_SUMMARY = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // classified command handed from front to back; times already masked
  typedef struct packed {
    logic [1:0]            op;
    logic [MAX_TIME_W-1:0] arm_time;
    logic [IV_W-1:0]       interval;
    logic [HDL_W-1:0]      handle;
    logic [MAX_TIME_W-1:0] now;
  } cmd_t;

endpackage

FILE: src/tpq_if.sv
// ----------------------------------------------------------------------------
// tpq_if
// Valid/ready channels for timer queue commands and results.
// ----------------------------------------------------------------------------
interface tpq_in_if;
  import tpq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [IN_TIME_W-1:0] arm_time;
  logic [IV_W-1:0]      repeat_interval;
  logic [HDL_W-1:0]     handle_in;
  logic [IN_TIME_W-1:0] current_time;

  modport source(output valid, op, arm_time, repeat_interval, handle_in, current_time,
                 input ready);
  modport sink(input valid, op, arm_time, repeat_interval, handle_in, current_time,
               output ready);
endinterface

interface tpq_out_if;
  import tpq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [1:0]            status;
  logic [HDL_W-1:0]      handle_out;
  logic [CNT_W-1:0]      fired_count;
  logic                  more_pending;
  logic [CNT_W-1:0]      live_count;
  logic [OUT_TIME_W-1:0] time_to_next;
  logic                  last;

  modport source(output valid, kind, status, handle_out, fired_count, more_pending,
                 live_count, time_to_next, last, input ready);
  modport sink(input valid, kind, status, handle_out, fired_count, more_pending,
               live_count, time_to_next, last, output ready);
endinterface

FILE: src/tpq_front.sv
// ----------------------------------------------------------------------------
// tpq_front
// Accepts command beats, masks times to the timer width and queues them in
// a two-entry buffer for the back end.
// ----------------------------------------------------------------------------
module tpq_front import tpq_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic   clk,
  input  logic   rst_n,
  tpq_in_if.sink in_ch,
  output logic   cmd_valid,
  input  logic   cmd_pop,
  output cmd_t   cmd
);

  localparam logic [MAX_TIME_W-1:0] TMASK = {MAX_TIME_W{1'b1}} >> (MAX_TIME_W - TIME_BITS);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  logic       push;
  cmd_t       cls;

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  // classify: normalize times, keep only what the op uses
  always_comb begin
    cls.op        = in_ch.op;
    cls.arm_time  = (in_ch.op == OP_SCHED) ? (MAX_TIME_W'(in_ch.arm_time) & TMASK) : '0;
    cls.interval  = (in_ch.op == OP_SCHED) ? in_ch.repeat_interval : '0;
    cls.handle    = (in_ch.op == OP_CANCEL) ? in_ch.handle_in : '0;
    cls.now       = MAX_TIME_W'(in_ch.current_time) & TMASK;
  end

  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      fill_r <= fill_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

FILE: src/tpq_back.sv
// ----------------------------------------------------------------------------
// tpq_back
// Executes commands against the timer store: linear scans for the earliest
// timer and for a handle, removal by moving the last entry, re-arming, and
// the registered result beat.
// ----------------------------------------------------------------------------
module tpq_back import tpq_pkg::*; #(
  parameter int DEPTH     = 32,
  parameter int TIME_BITS = 48,
  parameter int MAX_FIRES = 63
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_pop,
  input  cmd_t                       cmd,
  tpq_out_if.source                  out_ch,
  output logic [$clog2(DEPTH+1)-1:0] live_cnt
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int TB = TIME_BITS;
  localparam int EW = TB + IV_W + HDL_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;

  // timer store: {when, interval, handle}
  logic [EW-1:0] mem [DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [HDL_W-1:0] next_hdl_r, next_hdl_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [TB-1:0]    now_r, now_nxt;
  logic [HDL_W-1:0] hin_r, hin_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [HDL_W-1:0] handle_r, handle_nxt;
  logic             find_r, find_nxt;
  logic [CNT_W-1:0] fired_r, fired_nxt;
  logic             pend_r, pend_nxt;
  logic [HDL_W-1:0] fire_hdl_r, fire_hdl_nxt;
  logic [CW-1:0]    scan_idx_r, scan_idx_nxt;
  logic             rdv_r, rdv_nxt;
  logic [EW-1:0]    rd_data_r;
  logic             best_valid_r, best_valid_nxt;
  logic [AW-1:0]    best_slot_r, best_slot_nxt;
  logic [TB-1:0]    best_when_r, best_when_nxt;
  logic [IV_W-1:0]  best_iv_r, best_iv_nxt;
  logic [HDL_W-1:0] best_hdl_r, best_hdl_nxt;
  logic             found_r, found_nxt;
  logic [AW-1:0]    match_slot_r, match_slot_nxt;
  logic [AW-1:0]    move_dst_r, move_dst_nxt;
  logic [AW-1:0]    rd_slot_r, rd_slot_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            o_kind_r, o_kind_nxt;
  logic [1:0]            o_status_r, o_status_nxt;
  logic [HDL_W-1:0]      o_hdl_r, o_hdl_nxt;
  logic [CNT_W-1:0]      o_fired_r, o_fired_nxt;
  logic                  o_more_r, o_more_nxt;
  logic [CNT_W-1:0]      o_live_r, o_live_nxt;
  logic [OUT_TIME_W-1:0] o_ttn_r, o_ttn_nxt;
  logic                  o_last_r, o_last_nxt;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [EW-1:0] wd;
  logic          out_free, start_scan;
  logic [TB-1:0] rd_when;
  logic [IV_W-1:0]  rd_iv;
  logic [HDL_W-1:0] rd_hdl;
  logic [TB-1:0] diff;
  logic [OUT_TIME_W-1:0] gap_sat;
  logic [TB+IV_W:0] sum;
  logic [TB-1:0] rearm;
  logic [AW-1:0] last_slot;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign rd_when   = rd_data_r[EW-1 -: TB];
  assign rd_iv     = rd_data_r[HDL_W +: IV_W];
  assign rd_hdl    = rd_data_r[HDL_W-1:0];
  assign last_slot = AW'(count_r - CW'(1));
  assign live_cnt  = count_r;

  // distance to the earliest timer, saturated to the field
  always_comb begin
    diff = best_when_r - now_r;
    if (!best_valid_r) begin
      gap_sat = '1;
    end else if (best_when_r <= now_r) begin
      gap_sat = '0;
    end else if (MAX_TIME_W'(diff) > MAX_TIME_W'({OUT_TIME_W{1'b1}})) begin
      gap_sat = '1;
    end else begin
      gap_sat = OUT_TIME_W'(diff);
    end
  end

  // re-armed fire time, saturated at the largest time value
  always_comb begin
    sum   = (TB+IV_W+1)'(best_when_r) + (TB+IV_W+1)'(best_iv_r);
    rearm = (sum[TB+IV_W:TB] != '0) ? '1 : sum[TB-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    next_hdl_nxt   = next_hdl_r;
    op_nxt         = op_r;
    now_nxt        = now_r;
    hin_nxt        = hin_r;
    status_nxt     = status_r;
    handle_nxt     = handle_r;
    find_nxt       = find_r;
    fired_nxt      = fired_r;
    pend_nxt       = pend_r;
    fire_hdl_nxt   = fire_hdl_r;
    scan_idx_nxt   = scan_idx_r;
    rdv_nxt        = 1'b0;
    rd_slot_nxt    = rd_slot_r;
    best_valid_nxt = best_valid_r;
    best_slot_nxt  = best_slot_r;
    best_when_nxt  = best_when_r;
    best_iv_nxt    = best_iv_r;
    best_hdl_nxt   = best_hdl_r;
    found_nxt      = found_r;
    match_slot_nxt = match_slot_r;
    move_dst_nxt   = move_dst_r;
    cmd_pop        = 1'b0;
    we             = 1'b0;
    wa             = '0;
    wd             = '0;
    ra             = scan_idx_r[AW-1:0];
    start_scan     = 1'b0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_kind_nxt    = o_kind_r;
    o_status_nxt  = o_status_r;
    o_hdl_nxt     = o_hdl_r;
    o_fired_nxt   = o_fired_r;
    o_more_nxt    = o_more_r;
    o_live_nxt    = o_live_r;
    o_ttn_nxt     = o_ttn_r;
    o_last_nxt    = o_last_r;

    // compare the entry read last cycle
    if (rdv_r) begin
      if (!best_valid_r || rd_when < best_when_r ||
          (rd_when == best_when_r && rd_hdl < best_hdl_r)) begin
        best_valid_nxt = 1'b1;
        best_slot_nxt  = rd_slot_r;
        best_when_nxt  = rd_when;
        best_iv_nxt    = rd_iv;
        best_hdl_nxt   = rd_hdl;
      end
      if (!found_r && rd_hdl == hin_r) begin
        found_nxt      = 1'b1;
        match_slot_nxt = rd_slot_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          op_nxt     = cmd.op;
          now_nxt    = cmd.now[TB-1:0];
          hin_nxt    = cmd.handle;
          status_nxt = ST_OK;
          handle_nxt = '0;
          find_nxt   = 1'b0;
          fired_nxt  = '0;
          pend_nxt   = 1'b0;
          start_scan = 1'b1;
          case (cmd.op)
            OP_SCHED: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                we           = 1'b1;
                wa           = count_r[AW-1:0];
                wd           = {cmd.arm_time[TB-1:0], cmd.interval, next_hdl_r};
                handle_nxt   = next_hdl_r;
                next_hdl_nxt = next_hdl_r + HDL_W'(1);
                count_nxt    = count_r + CW'(1);
              end
            end
            OP_CANCEL: find_nxt  = 1'b1;
            OP_CLEAR:  count_nxt = '0;
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (scan_idx_r < count_r) begin
          ra           = scan_idx_r[AW-1:0];
          rdv_nxt      = 1'b1;
          rd_slot_nxt  = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else if (!rdv_r) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (pend_r) begin
          // fired beat, reported against the store after the fire
          if (out_free) begin
            out_valid_nxt = 1'b1;
            o_kind_nxt    = KIND_FIRED;
            o_status_nxt  = ST_OK;
            o_hdl_nxt     = fire_hdl_r;
            o_fired_nxt   = fired_r;
            o_more_nxt    = 1'b0;
            o_live_nxt    = CNT_W'(count_r);
            o_ttn_nxt     = gap_sat;
            o_last_nxt    = 1'b0;
            pend_nxt      = 1'b0;
          end
        end else if (find_r) begin
          // cancel lookup finished
          if (found_r) begin
            find_nxt  = 1'b0;
            count_nxt = count_r - CW'(1);
            if (match_slot_r != last_slot) begin
              move_dst_nxt = match_slot_r;
              state_nxt    = S_MOVE_RD;
            end else begin
              start_scan = 1'b1;
            end
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            o_kind_nxt    = KIND_CANCEL;
            o_status_nxt  = ST_NOTFOUND;
            o_hdl_nxt     = hin_r;
            o_fired_nxt   = '0;
            o_more_nxt    = 1'b0;
            o_live_nxt    = CNT_W'(count_r);
            o_ttn_nxt     = gap_sat;
            o_last_nxt    = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (op_r == OP_PROCESS) begin
          if (!best_valid_r || best_when_r > now_r || fired_r >= CNT_W'(MAX_FIRES)) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              o_kind_nxt    = KIND_SUMMARY;
              o_status_nxt  = ST_OK;
              o_hdl_nxt     = '0;
              o_fired_nxt   = fired_r;
              o_more_nxt    = best_valid_r && best_when_r <= now_r;
              o_live_nxt    = CNT_W'(count_r);
              o_ttn_nxt     = gap_sat;
              o_last_nxt    = 1'b1;
              state_nxt     = S_IDLE;
            end
          end else begin
            // fire the earliest timer
            fire_hdl_nxt = best_hdl_r;
            fired_nxt    = fired_r + CNT_W'(1);
            pend_nxt     = 1'b1;
            if (best_iv_r != '0) begin
              we         = 1'b1;
              wa         = best_slot_r;
              wd         = {rearm, best_iv_r, best_hdl_r};
              start_scan = 1'b1;
            end else begin
              count_nxt = count_r - CW'(1);
              if (best_slot_r != last_slot) begin
                move_dst_nxt = best_slot_r;
                state_nxt    = S_MOVE_RD;
              end else begin
                start_scan = 1'b1;
              end
            end
          end
        end else if (out_free) begin
          // final beat of schedule, cancel hit or clear
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_fired_nxt   = '0;
          o_more_nxt    = 1'b0;
          o_live_nxt    = CNT_W'(count_r);
          o_ttn_nxt     = gap_sat;
          o_last_nxt    = 1'b1;
          case (op_r)
            OP_SCHED: begin
              o_kind_nxt = KIND_SCHED;
              o_hdl_nxt  = handle_r;
            end
            OP_CANCEL: begin
              o_kind_nxt = KIND_CANCEL;
              o_hdl_nxt  = hin_r;
            end
            default: begin
              o_kind_nxt = KIND_CLEAR;
              o_hdl_nxt  = '0;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      S_MOVE_RD: begin
        // count already dropped: it indexes the old last entry
        ra        = count_r[AW-1:0];
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        we         = 1'b1;
        wa         = move_dst_r;
        wd         = rd_data_r;
        start_scan = 1'b1;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (start_scan) begin
      scan_idx_nxt   = '0;
      best_valid_nxt = 1'b0;
      found_nxt      = 1'b0;
      state_nxt      = S_SCAN;
    end
  end

  // store
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_hdl_r  <= '0;
      pend_r      <= 1'b0;
      find_r      <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_hdl_r  <= next_hdl_nxt;
      pend_r      <= pend_nxt;
      find_r      <= find_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    now_r        <= now_nxt;
    hin_r        <= hin_nxt;
    status_r     <= status_nxt;
    handle_r     <= handle_nxt;
    fired_r      <= fired_nxt;
    fire_hdl_r   <= fire_hdl_nxt;
    scan_idx_r   <= scan_idx_nxt;
    rd_slot_r    <= rd_slot_nxt;
    best_valid_r <= best_valid_nxt;
    best_slot_r  <= best_slot_nxt;
    best_when_r  <= best_when_nxt;
    best_iv_r    <= best_iv_nxt;
    best_hdl_r   <= best_hdl_nxt;
    found_r      <= found_nxt;
    match_slot_r <= match_slot_nxt;
    move_dst_r   <= move_dst_nxt;
    o_kind_r     <= o_kind_nxt;
    o_status_r   <= o_status_nxt;
    o_hdl_r      <= o_hdl_nxt;
    o_fired_r    <= o_fired_nxt;
    o_more_r     <= o_more_nxt;
    o_live_r     <= o_live_nxt;
    o_ttn_r      <= o_ttn_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = o_kind_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.handle_out   = o_hdl_r;
  assign out_ch.fired_count  = o_fired_r;
  assign out_ch.more_pending = o_more_r;
  assign out_ch.live_count   = o_live_r;
  assign out_ch.time_to_next = o_ttn_r;
  assign out_ch.last         = o_last_r;

endmodule

FILE: src/timer_priority_queue_core.sv
// ----------------------------------------------------------------------------
// timer_priority_queue_core
// Timer queue of up to DEPTH timers ordered by fire time, then handle.
//
// in_ch carries command beats (schedule, cancel, process, clear); out_ch
// carries result beats, last set on the final beat of each command. A
// process command yields one fired beat per due timer, up to MAX_FIRES, and
// a summary beat. A two-entry command buffer lets in_ch take beats while
// the back end works or out_ch is stalled. Each command runs on its own:
// every result needs a linear scan of the live timers in the store through
// its single read port. Schedule, clear and a cancel miss take one scan; a
// cancel hit two scans and a possible move of the last entry (read, then
// write); each fired timer one more scan and a possible move. A stalled
// out_ch holds the result register and halts the back end when it has a
// beat to send; commands keep queueing until the buffer is full. Reset
// empties the store and sets the next handle to zero at once; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module timer_priority_queue_core import tpq_pkg::*; #(
  parameter int DEPTH     = 32,
  parameter int TIME_BITS = 48,
  parameter int MAX_FIRES = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  tpq_in_if.sink    in_ch,
  tpq_out_if.source out_ch
);

  logic                       cmd_valid;
  logic                       cmd_pop;
  cmd_t                       cmd;
  logic [$clog2(DEPTH+1)-1:0] live_cnt;

  tpq_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  tpq_back #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS),
    .MAX_FIRES (MAX_FIRES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_ch    (out_ch),
    .live_cnt  (live_cnt)
  );

  // store never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(live_cnt) <= 32'(DEPTH))
    else $error("timer count above depth");

  // fired beats never close a command
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_FIRED) |-> (!out_ch.last && out_ch.fired_count != '0))
    else $error("fired beat marked last or with zero count");

  // every other beat closes its command
  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind != KIND_FIRED) |-> out_ch.last)
    else $error("final beat without last");

  // clear leaves an empty store
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_CLEAR) |->
      (out_ch.live_count == '0 && out_ch.time_to_next == '1))
    else $error("clear did not empty the store");

endmodule
